>>> hw/rtl/rdc_pkg.sv
// rdc_pkg: shared types, constants and helpers for the radix digit converter
// used by rdc_ctrl, rdc_dpath and radix_digit_converter; no dependencies
package rdc_pkg;

  // fixed widths of the item fields
  localparam int RDC_VALUE_WIDTH = 31;
  localparam int RDC_RADIX_WIDTH = 5;
  localparam int RDC_CHAR_WIDTH  = 7;
  localparam int RDC_DIGIT_WIDTH = 4;
  localparam int RDC_BIT_W       = $clog2(RDC_VALUE_WIDTH);
  localparam int RDC_MAX_DIGITS  = 31;

  // radix limits and character codes
  localparam logic [RDC_RADIX_WIDTH-1:0] RDC_RADIX_MIN = 5'd2;
  localparam logic [RDC_RADIX_WIDTH-1:0] RDC_RADIX_MAX = 5'd16;
  localparam logic [RDC_CHAR_WIDTH-1:0]  RDC_ASCII_ZERO = 7'd48;
  localparam logic [RDC_CHAR_WIDTH-1:0]  RDC_ASCII_A    = 7'd65;
  localparam logic [RDC_DIGIT_WIDTH-1:0] RDC_DEC_BASE   = 4'd10;

  // input item
  typedef struct packed {
    logic [RDC_VALUE_WIDTH-1:0] value;
    logic [RDC_RADIX_WIDTH-1:0] radix;
  } rdc_in_t;

  // result item
  typedef struct packed {
    logic [RDC_CHAR_WIDTH-1:0] digit_char;
    logic                      last_digit;
  } rdc_out_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_READ,
    ST_EMIT
  } rdc_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic rd_issue;
    logic emit;
  } rdc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bit_last;
    logic quo_zero;
    logic idx_zero;
  } rdc_sts_t;

  // digit value to ascii character
  function automatic logic [RDC_CHAR_WIDTH-1:0] digit_to_ascii(
    input logic [RDC_DIGIT_WIDTH-1:0] d
  );
    logic [RDC_CHAR_WIDTH-1:0] c;
    if (d < RDC_DEC_BASE) begin
      c = RDC_ASCII_ZERO + RDC_CHAR_WIDTH'(d);
    end else begin
      c = RDC_ASCII_A + RDC_CHAR_WIDTH'(d - RDC_DEC_BASE);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/radix_digit_converter.sv
// radix_digit_converter: top level, joins the controller and the datapath
// depends on rdc_pkg, rdc_ctrl and rdc_dpath
//
// Converts a 31-bit unsigned value to ASCII digits in radix 2..16 (radix
// values outside that range saturate). An item is taken when start is high
// and busy is low. Each digit is divided out by a bit-serial restoring
// divider, one quotient bit per cycle, in 31 division steps followed by one
// push into the digit stack. Digits then leave most significant first, each
// through a stack read and then an output state, and each is shown for a
// single cycle with out_valid high; the receiver cannot stall them and must
// take every one. The least significant digit carries last_digit. Zero gives
// one digit '0'. Busy stays high from the edge that takes an item until its
// last digit has been output; an item gives at most 31 digits, in radix 2.
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int MAX_DIGITS = RDC_MAX_DIGITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rdc_in_t  in_item,
  output logic     out_valid,
  output rdc_out_t out_item
);

  rdc_cmd_t cmd;
  rdc_sts_t sts;

  // sequencer
  rdc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // divider, digit stack and readout
  rdc_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  assign out_valid = cmd.emit;

endmodule

>>> hw/rtl/rdc_ctrl.sv
// rdc_ctrl: sequencer for division, digit push and digit readout
// depends on rdc_pkg
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  rdc_sts_t sts,
  output rdc_cmd_t cmd,
  output logic     busy
);

  rdc_state_t state_r;
  rdc_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.bit_last) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        state_nxt = sts.quo_zero ? ST_READ : ST_DIV;
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        state_nxt = sts.idx_zero ? ST_IDLE : ST_READ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_PUSH: cmd.push     = 1'b1;
      ST_READ: cmd.rd_issue = 1'b1;
      ST_EMIT: cmd.emit     = 1'b1;
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/rdc_dpath.sv
// rdc_dpath: bit-serial radix divider, digit stack memory and readout index
// depends on rdc_pkg
module rdc_dpath
  import rdc_pkg::*;
#(
  parameter int MAX_DIGITS = RDC_MAX_DIGITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  rdc_in_t  in_item,
  input  rdc_cmd_t cmd,
  output rdc_sts_t sts,
  output rdc_out_t out_item
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [RDC_VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [RDC_DIGIT_WIDTH-1:0] rem_r, rem_nxt;
  logic [RDC_RADIX_WIDTH-1:0] radix_r, radix_nxt;
  logic [RDC_BIT_W-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]           rd_idx_r, rd_idx_nxt;
  logic [RDC_DIGIT_WIDTH-1:0] rd_data_r;
  logic [RDC_DIGIT_WIDTH-1:0] stack_mem [MAX_DIGITS];

  logic [RDC_RADIX_WIDTH-1:0] radix_sat;
  logic [RDC_RADIX_WIDTH-1:0] rem_shift;
  logic [RDC_RADIX_WIDTH-1:0] rem_diff;
  logic                       rem_ge;
  logic                       has_room;

  // clamp the radix into its legal range
  always_comb begin
    if (in_item.radix < RDC_RADIX_MIN) begin
      radix_sat = RDC_RADIX_MIN;
    end else if (in_item.radix > RDC_RADIX_MAX) begin
      radix_sat = RDC_RADIX_MAX;
    end else begin
      radix_sat = in_item.radix;
    end
  end

  // one restoring division step: shift in the next dividend bit
  assign rem_shift = {rem_r, quo_r[RDC_VALUE_WIDTH-1]};
  assign rem_ge    = (rem_shift >= radix_r);
  assign rem_diff  = rem_shift - radix_r;
  assign has_room  = (count_r < CNT_W'(MAX_DIGITS));

  // next values
  always_comb begin
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    radix_nxt   = radix_r;
    bit_cnt_nxt = bit_cnt_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    if (cmd.load) begin
      quo_nxt     = in_item.value;
      rem_nxt     = '0;
      radix_nxt   = radix_sat;
      bit_cnt_nxt = '0;
      count_nxt   = '0;
    end
    if (cmd.div_step) begin
      quo_nxt     = {quo_r[RDC_VALUE_WIDTH-2:0], rem_ge};
      rem_nxt     = rem_ge ? rem_diff[RDC_DIGIT_WIDTH-1:0]
                           : rem_shift[RDC_DIGIT_WIDTH-1:0];
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end
    // digits beyond the stack depth are dropped, keeping the low-order ones
    if (cmd.push) begin
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      if (has_room) begin
        count_nxt  = count_r + 1'b1;
        rd_idx_nxt = count_r[IDX_W-1:0];
      end
    end
    if (cmd.emit) begin
      rd_idx_nxt = rd_idx_r - 1'b1;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    radix_r   <= radix_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
  end

  // digit stack: written on push, read registered
  always_ff @(posedge clk) begin
    if (cmd.push && has_room) begin
      stack_mem[count_r[IDX_W-1:0]] <= rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= stack_mem[rd_idx_r];
    end
  end

  // status to the controller
  assign sts.bit_last = (bit_cnt_r == RDC_BIT_W'(RDC_VALUE_WIDTH - 1));
  assign sts.quo_zero = (quo_r == '0);
  assign sts.idx_zero = (rd_idx_r == '0);

  // result item
  assign out_item.digit_char = digit_to_ascii(rd_data_r);
  assign out_item.last_digit = (rd_idx_r == '0);

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for radix_digit_converter, directed and random items
// depends on rdc_pkg and the radix_digit_converter rtl
module tb;
  import rdc_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  rdc_in_t  in_item;
  logic     out_valid;
  rdc_out_t out_item;

  // expected digit characters, oldest first
  rdc_out_t expected_digits[$];
  int       mismatch_count;
  int       items_sent;
  int       digits_checked;
  int       saturated_radix_items;

  radix_digit_converter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // digits of one conversion, most significant first, into the expected queue
  function automatic void predict_digits(input rdc_in_t it);
    logic [RDC_RADIX_WIDTH-1:0] base;
    logic [RDC_VALUE_WIDTH-1:0] rem;
    logic [RDC_DIGIT_WIDTH-1:0] digs [0:RDC_MAX_DIGITS-1];
    rdc_out_t                   o;
    int                         n;
    base = it.radix;
    if (base < RDC_RADIX_MIN) begin
      base = RDC_RADIX_MIN;
    end
    if (base > RDC_RADIX_MAX) begin
      base = RDC_RADIX_MAX;
    end
    rem = it.value;
    n   = 0;
    // remainders come out least significant first
    do begin
      if (n < RDC_MAX_DIGITS) begin
        digs[n] = RDC_DIGIT_WIDTH'(rem % base);
        n++;
      end
      rem = rem / base;
    end while (rem != '0);
    for (int k = n - 1; k >= 0; k--) begin
      if (digs[k] < RDC_DEC_BASE) begin
        o.digit_char = RDC_ASCII_ZERO + RDC_CHAR_WIDTH'(digs[k]);
      end else begin
        o.digit_char = RDC_ASCII_A + RDC_CHAR_WIDTH'(digs[k] - RDC_DEC_BASE);
      end
      o.last_digit = (k == 0);
      expected_digits.push_back(o);
    end
  endfunction

  // idle cycles between items: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 6);
    end
    return $urandom_range(30, 1200);
  endfunction

  // offer one item, wait for it to be taken, then maybe idle
  task automatic send_conversion(input logic [RDC_VALUE_WIDTH-1:0] v,
                                 input logic [RDC_RADIX_WIDTH-1:0] r);
    rdc_in_t it;
    int      gap;
    it.value = v;
    it.radix = r;
    start   <= 1'b1;
    in_item <= it;
    do begin
      @(posedge clk);
    end while (busy);
    predict_digits(it);
    items_sent++;
    if (r < RDC_RADIX_MIN || r > RDC_RADIX_MAX) begin
      saturated_radix_items++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // zero, one and full-scale values in the narrowest and widest bases and in bases 3 and 10
  task automatic test_value_extremes();
    send_conversion('0, 5'd10);
    send_conversion('0, RDC_RADIX_MIN);
    send_conversion(31'd1, RDC_RADIX_MIN);
    send_conversion('1, RDC_RADIX_MIN);
    send_conversion('1, RDC_RADIX_MAX);
    send_conversion('1, 5'd10);
    send_conversion('1, 5'd3);
    send_conversion(31'd1, RDC_RADIX_MAX);
  endtask

  // radix below two and above sixteen
  task automatic test_radix_saturation();
    send_conversion(31'd255, 5'd0);
    send_conversion(31'd255, 5'd1);
    send_conversion(31'd255, 5'd17);
    send_conversion(31'd255, 5'd31);
    send_conversion('0, 5'd31);
  endtask

  // letter digits and decimal carry boundaries
  task automatic test_letter_digits();
    send_conversion(31'd15, RDC_RADIX_MAX);
    send_conversion(31'd10, RDC_RADIX_MAX);
    send_conversion(31'h7ABCDEF0, RDC_RADIX_MAX);
    send_conversion(31'd9, 5'd10);
    send_conversion(31'd10, 5'd10);
    send_conversion(31'd120, 5'd11);
    send_conversion('1, 5'd7);
  endtask

  // random values of assorted magnitudes, mostly legal radix
  task automatic test_random_values(input int count);
    logic [RDC_VALUE_WIDTH-1:0] v;
    logic [RDC_RADIX_WIDTH-1:0] r;
    int                         roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        v = RDC_VALUE_WIDTH'($urandom);
      end else if (roll < 70) begin
        v = RDC_VALUE_WIDTH'($urandom_range(0, 1000));
      end else if (roll < 90) begin
        v = RDC_VALUE_WIDTH'((64'd1 << $urandom_range(0, 30)) - $urandom_range(0, 1));
      end else begin
        v = ($urandom_range(0, 1) != 0) ? '1 : '0;
      end
      if ($urandom_range(0, 99) < 85) begin
        r = RDC_RADIX_WIDTH'($urandom_range(RDC_RADIX_MIN, RDC_RADIX_MAX));
      end else begin
        r = RDC_RADIX_WIDTH'($urandom_range(0, 31));
      end
      send_conversion(v, r);
    end
  endtask

  // every strobed digit is compared with the oldest expectation
  always @(posedge clk) begin
    rdc_out_t exp_d;
    if (rst_n && out_valid) begin
      if (expected_digits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("tb: unexpected digit char=%0d last=%0b",
                   out_item.digit_char, out_item.last_digit);
        end
      end else begin
        exp_d = expected_digits.pop_front();
        digits_checked++;
        if (out_item.digit_char !== exp_d.digit_char ||
            out_item.last_digit !== exp_d.last_digit) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("tb: digit mismatch exp char=%0d last=%0b got char=%0d last=%0b",
                     exp_d.digit_char, exp_d.last_digit,
                     out_item.digit_char, out_item.last_digit);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #40_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    start                 = 1'b0;
    in_item               = '0;
    mismatch_count        = 0;
    items_sent            = 0;
    digits_checked        = 0;
    saturated_radix_items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_value_extremes();
    test_radix_saturation();
    test_letter_digits();
    test_random_values(90);

    // let the last conversion finish and drain
    start <= 1'b0;
    do begin
      @(posedge clk);
    end while (busy);
    repeat (50) @(posedge clk);
    if (expected_digits.size() != 0) begin
      mismatch_count++;
      $display("tb: %0d expected digits never arrived", expected_digits.size());
    end

    $display("tb: %0d conversions, %0d with out-of-range radix, %0d digits checked",
             items_sent, saturated_radix_items, digits_checked);
    $display("tb: %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_ctrl.sv
hw/rtl/rdc_dpath.sv
hw/rtl/radix_digit_converter.sv
verif/tb.sv
